[sv/ternary_row_engine_assert.svh]
// Assertion helpers shared by the RTL files of the ternary row engine.
`ifndef TERNARY_ROW_ENGINE_ASSERT_SVH
`define TERNARY_ROW_ENGINE_ASSERT_SVH

// Check that a property holds at every clock edge outside reset.
`define TRE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define TRE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[sv/tre_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tre_pkg;

  localparam int LANES          = 4;
  localparam int TRIT_W         = 2;
  localparam int WEIGHT_W       = LANES * TRIT_W;
  localparam int ACT_WIDTH_DEF  = 16;
  localparam int ACC_WIDTH_DEF  = 32;
  localparam int BIAS_W         = 16;
  localparam int DECAY_W        = 13;
  localparam int PREV_W         = 16;
  localparam int OUT_W          = 16;
  localparam int MODE_W         = 2;
  localparam int G_W            = 13;        // sigmoid value, 0 .. 1.0 in Q.12

  localparam int FRAC           = 12;
  localparam int ONE_Q          = 4096;
  localparam int HALF_Q         = 2048;
  localparam int OUT_MAX        = 32767;
  localparam int OUT_MIN        = -32768;

  // Sigmoid polynomial: 0.5 + x * (0.25 - |x| / 32), x clamped at +-4.0
  localparam int SIG_LIMIT      = 16384;
  localparam int SIG_QUARTER    = 4194304;   // 0.25 in Q.24
  localparam int SIG_SLOPE_SH   = 7;         // |x| / 32 in Q.24 from Q.12
  // Rational tanh: x * (27 + x^2) / (27 + 9 x^2), x clamped at +-3.0
  localparam int TANH_LIMIT     = 12288;
  localparam int TANH_K27       = 452984832; // 27.0 in Q.24
  localparam int GATE_CLAMP     = 268435456; // gated operand clamp, 2^28

  // Tanh divider geometry
  localparam int DIV_DIVIDEND_W = 45;
  localparam int DIV_DIVISOR_W  = 31;
  localparam int DIV_QUOT_W     = 14;

  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam logic REG_MODE_IDX = 1'b0;

  localparam logic [TRIT_W-1:0] TRIT_MASK = 2'h3;

  typedef enum logic [TRIT_W-1:0] {
    TRIT_ZERO = 2'd0,
    TRIT_POS  = 2'd1,
    TRIT_NEG  = 2'd2
  } trit_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAIN = 2'd0,
    MODE_GATED = 2'd1,
    MODE_CELL  = 2'd2
  } mode_e;

  typedef struct packed {
    logic busy;
    logic done;
  } fin_stat_t;

endpackage

`default_nettype wire

[sv/tre_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module tre_lane #(
  parameter int ACT_WIDTH = tre_pkg::ACT_WIDTH_DEF
) (
  input  logic [tre_pkg::TRIT_W-1:0] trit_a_i,
  input  logic [tre_pkg::TRIT_W-1:0] trit_b_i,
  input  logic signed [ACT_WIDTH-1:0] act_i,
  output logic signed [ACT_WIDTH:0]   contrib_a_o,
  output logic signed [ACT_WIDTH:0]   contrib_b_o
);
  import tre_pkg::*;

  logic signed [ACT_WIDTH:0] act_x;

  assign act_x = (ACT_WIDTH + 1)'(act_i);

  // Decode one trit per row: add, subtract or drop the activation.
  always_comb begin
    case (trit_a_i & TRIT_MASK)
      TRIT_POS: contrib_a_o = act_x;
      TRIT_NEG: contrib_a_o = -act_x;
      default:  contrib_a_o = '0;
    endcase
    case (trit_b_i & TRIT_MASK)
      TRIT_POS: contrib_b_o = act_x;
      TRIT_NEG: contrib_b_o = -act_x;
      default:  contrib_b_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/tre_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

module tre_divider #(
  parameter int DIVIDEND_W = tre_pkg::DIV_DIVIDEND_W,
  parameter int DIVISOR_W  = tre_pkg::DIV_DIVISOR_W,
  parameter int QUOT_W     = tre_pkg::DIV_QUOT_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [QUOT_W-1:0]     quot_o
);
  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [DIVIDEND_W-1:0] rem_q, rem_d;
  logic [DIVIDEND_W-1:0] dsh_q, dsh_d;
  logic [QUOT_W-1:0]     quot_q, quot_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign fits = rem_q >= dsh_q;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dsh_d  = DIVIDEND_W'(divisor_i) << (QUOT_W - 1);
      quot_d = '0;
      cnt_d  = CNT_W'(QUOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? rem_q - dsh_q : rem_q;
      dsh_d  = dsh_q >> 1;
      quot_d = {quot_q[QUOT_W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[sv/tre_accum.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ternary_row_engine_assert.svh"

module tre_accum #(
  parameter int ACT_WIDTH = tre_pkg::ACT_WIDTH_DEF,
  parameter int ACC_WIDTH = tre_pkg::ACC_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         row_end_i,
  input  logic [tre_pkg::WEIGHT_W-1:0] weight_a_i,
  input  logic [tre_pkg::WEIGHT_W-1:0] weight_b_i,
  input  logic signed [ACT_WIDTH-1:0]  act_i [tre_pkg::LANES],
  output logic signed [ACC_WIDTH-1:0]  sum_a_o,
  output logic signed [ACC_WIDTH-1:0]  sum_b_o
);
  import tre_pkg::*;

  localparam int DW = ACT_WIDTH + 3;
  localparam int SW = ((ACC_WIDTH > DW) ? ACC_WIDTH : DW) + 1;
  localparam logic signed [SW-1:0] ACC_MAX = {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_MIN = {{(SW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

  logic signed [ACT_WIDTH:0]     ca [LANES];
  logic signed [ACT_WIDTH:0]     cb [LANES];
  logic signed [DW-1:0]          da, db;
  logic signed [SW-1:0]          wa, wb;
  logic signed [ACC_WIDTH-1:0]   sum_a_q, sum_a_d;
  logic signed [ACC_WIDTH-1:0]   sum_b_q, sum_b_d;

  function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [SW-1:0] v);
    logic signed [ACC_WIDTH-1:0] r;
    if (v > ACC_MAX) begin
      r = ACC_MAX[ACC_WIDTH-1:0];
    end else if (v < ACC_MIN) begin
      r = ACC_MIN[ACC_WIDTH-1:0];
    end else begin
      r = v[ACC_WIDTH-1:0];
    end
    return r;
  endfunction

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    tre_lane #(
      .ACT_WIDTH (ACT_WIDTH)
    ) u_lane (
      .trit_a_i    (weight_a_i[TRIT_W*k +: TRIT_W]),
      .trit_b_i    (weight_b_i[TRIT_W*k +: TRIT_W]),
      .act_i       (act_i[k]),
      .contrib_a_o (ca[k]),
      .contrib_b_o (cb[k])
    );
  end

  // Merge the lane contributions, then add with saturation.
  always_comb begin
    da = '0;
    db = '0;
    for (int k = 0; k < LANES; k++) begin
      da = da + DW'(ca[k]);
      db = db + DW'(cb[k]);
    end
    wa      = SW'(sum_a_q) + SW'(da);
    wb      = SW'(sum_b_q) + SW'(db);
    sum_a_d = sat_acc(wa);
    sum_b_d = sat_acc(wb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else if (accept_i) begin
      sum_a_q <= row_end_i ? '0 : sum_a_d;
      sum_b_q <= row_end_i ? '0 : sum_b_d;
    end
  end

  // Row totals including the current transfer.
  assign sum_a_o = sum_a_d;
  assign sum_b_o = sum_b_d;

  `TRE_ASSERT(a_clear_after_row, clk_i, rst_ni, (accept_i && row_end_i) |=> (sum_a_q == '0 && sum_b_q == '0), "accumulators not cleared after row end")

endmodule

`default_nettype wire

[sv/tre_finish.sv]
`timescale 1ns / 1ps
`default_nettype none

module tre_finish #(
  parameter int ACC_WIDTH = tre_pkg::ACC_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tre_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [ACC_WIDTH-1:0]       sum_a_i,
  input  logic signed [ACC_WIDTH-1:0]       sum_b_i,
  input  logic signed [tre_pkg::BIAS_W-1:0] bias_a_i,
  input  logic signed [tre_pkg::BIAS_W-1:0] bias_b_i,
  input  logic [tre_pkg::DECAY_W-1:0]       decay_i,
  input  logic signed [tre_pkg::PREV_W-1:0] prev_i,
  output tre_pkg::fin_stat_t                stat_o,
  output logic signed [tre_pkg::OUT_W-1:0]  result_o,
  output logic                              saturated_o
);
  import tre_pkg::*;

  localparam int XW = ACC_WIDTH + 1;
  localparam int GW = ACC_WIDTH + 14;
  localparam int RW = (ACC_WIDTH > 48) ? ACC_WIDTH : 48;
  localparam int QW = DIV_QUOT_W;

  localparam logic signed [XW-1:0] SIG_HI_X  = XW'(SIG_LIMIT);
  localparam logic signed [XW-1:0] SIG_LO_X  = -SIG_HI_X;
  localparam logic signed [XW-1:0] TANH_HI_X = XW'(TANH_LIMIT);
  localparam logic signed [XW-1:0] TANH_LO_X = -TANH_HI_X;
  localparam logic signed [39:0]   RND24_S   = 40'sd8388608;
  localparam logic signed [GW-1:0] RND12_G   = GW'(HALF_Q);
  localparam logic signed [GW-1:0] GCL_HI    = GW'(GATE_CLAMP);
  localparam logic signed [GW-1:0] GCL_LO    = -GCL_HI;
  localparam logic signed [59:0]   RND12_P   = 60'sd2048;
  localparam logic signed [45:0]   RND24_C   = 46'sd8388608;
  localparam logic signed [RW-1:0] OUT_HI    = RW'(OUT_MAX);
  localparam logic signed [RW-1:0] OUT_LO    = RW'(OUT_MIN);
  localparam logic signed [QW-1:0] C_ONE     = QW'(ONE_Q);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_PREP = 10'b0000000010,
    ST_SIG  = 10'b0000000100,
    ST_GATE = 10'b0000001000,
    ST_MULA = 10'b0000010000,
    ST_DVST = 10'b0000100000,
    ST_DIV  = 10'b0001000000,
    ST_MULB = 10'b0010000000,
    ST_MULC = 10'b0100000000,
    ST_OUT  = 10'b1000000000
  } fin_state_e;

  fin_state_e state_q, state_d;

  logic [MODE_W-1:0]         mode_q;
  logic signed [ACC_WIDTH-1:0] sa_q, sb_q;
  logic signed [BIAS_W-1:0]  bias_a_q, bias_b_q;
  logic [DECAY_W-1:0]        decay_q;
  logic signed [PREV_W-1:0]  prev_q;
  logic signed [XW-1:0]      xs_q, xs_d, xt_q, xt_d;
  logic signed [39:0]        sig_prod_q, sig_prod_d, sig_sum;
  logic [27:0]               x2_q, x2_d;
  logic [G_W-1:0]            g_q, g_d, g_poly;
  logic [29:0]               tsum_q, tsum_d;
  logic [30:0]               den_q, den_d;
  logic signed [GW-1:0]      gprod_q, gprod_d, silu_w, sb_w;
  logic [43:0]               mag_q, mag_d;
  logic signed [29:0]        keep1_q, keep1_d;
  logic signed [29:0]        silu_c_q, silu_c_d, sumb_c_q, sumb_c_d;
  logic signed [QW-1:0]      c_q, c_d;
  logic signed [59:0]        p_q, p_d, rg;
  logic signed [43:0]        keep_q, keep_d;
  logic signed [27:0]        mix_q, mix_d;
  logic signed [45:0]        cs;
  logic signed [RW-1:0]      rw;
  logic signed [OUT_W-1:0]   result_q, result_d;
  logic                      sat_q, sat_d;

  logic signed [15:0]        x16;
  logic [15:0]               ax16, axt16;
  logic [22:0]               inner;
  logic [13:0]               axt;
  logic                      sig_lo, sig_hi, t_lo, t_hi;
  logic                      div_start, div_done;
  logic [DIV_DIVIDEND_W-1:0] dividend;
  logic [QW-1:0]             quot;

  // Sigmoid input and tanh input, both clamped in range before use.
  assign x16    = xs_q[15:0];
  assign ax16   = xs_q[15] ? (~xs_q[15:0] + 16'd1) : xs_q[15:0];
  assign axt16  = xt_q[15] ? (~xt_q[15:0] + 16'd1) : xt_q[15:0];
  assign axt    = axt16[13:0];
  assign sig_lo = xs_q < SIG_LO_X;
  assign sig_hi = xs_q > SIG_HI_X;
  assign t_lo   = xt_q < TANH_LO_X;
  assign t_hi   = xt_q > TANH_HI_X;
  assign inner  = 23'(SIG_QUARTER) - {1'b0, ax16[14:0], 7'b0};

  assign xs_d = (mode_q == MODE_CELL) ? (XW'(sa_q) + XW'(bias_a_q)) : XW'(sa_q);
  assign xt_d = XW'(sb_q) + XW'(bias_b_q);

  assign sig_prod_d = x16 * $signed({1'b0, inner});
  assign x2_d       = axt * axt;

  assign sig_sum = sig_prod_q + RND24_S;
  assign g_poly  = G_W'(HALF_Q) + sig_sum[36:24];
  assign g_d     = sig_lo ? '0 : (sig_hi ? G_W'(ONE_Q) : g_poly);
  assign tsum_d  = 30'(TANH_K27) + {2'b0, x2_q};
  assign den_d   = 31'(TANH_K27) + {x2_q, 3'b0} + {3'b0, x2_q};

  assign gprod_d = sa_q * $signed({1'b0, g_q});
  assign mag_d   = axt * tsum_q;
  assign keep1_d = $signed({1'b0, G_W'(ONE_Q) - g_q}) * prev_q;

  assign dividend  = {1'b0, mag_q} + {15'b0, den_q[30:1]};
  assign div_start = (state_q == ST_DVST);

  tre_divider #(
    .DIVIDEND_W (DIV_DIVIDEND_W),
    .DIVISOR_W  (DIV_DIVISOR_W),
    .QUOT_W     (QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Gated operands: round silu to Q.12, clamp both sides of the product.
  assign silu_w = (gprod_q + RND12_G) >>> FRAC;
  assign sb_w   = GW'(sb_q);
  always_comb begin
    if (silu_w > GCL_HI) begin
      silu_c_d = GCL_HI[29:0];
    end else if (silu_w < GCL_LO) begin
      silu_c_d = GCL_LO[29:0];
    end else begin
      silu_c_d = silu_w[29:0];
    end
    if (sb_w > GCL_HI) begin
      sumb_c_d = GCL_HI[29:0];
    end else if (sb_w < GCL_LO) begin
      sumb_c_d = GCL_LO[29:0];
    end else begin
      sumb_c_d = sb_w[29:0];
    end
    if (t_lo) begin
      c_d = -C_ONE;
    end else if (t_hi) begin
      c_d = C_ONE;
    end else if (xt_q[XW-1]) begin
      c_d = $signed(~quot + QW'(1));
    end else begin
      c_d = $signed(quot);
    end
  end

  assign p_d    = silu_c_q * sumb_c_q;
  assign keep_d = keep1_q * $signed({1'b0, decay_q});
  assign mix_d  = $signed({1'b0, g_q}) * c_q;

  // Final rounding and output saturation.
  assign rg = (p_q + RND12_P) >>> FRAC;
  assign cs = (46'(keep_q) + 46'($signed({mix_q, 12'b0})) + RND24_C) >>> (2 * FRAC);
  always_comb begin
    case (mode_q)
      MODE_GATED: rw = rg[RW-1:0];
      MODE_CELL:  rw = RW'(cs);
      default:    rw = RW'(sa_q);
    endcase
    if (rw > OUT_HI) begin
      result_d = OUT_HI[OUT_W-1:0];
      sat_d    = 1'b1;
    end else if (rw < OUT_LO) begin
      result_d = OUT_LO[OUT_W-1:0];
      sat_d    = 1'b1;
    end else begin
      result_d = rw[OUT_W-1:0];
      sat_d    = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_PREP;
      ST_PREP: begin
        if (mode_q == MODE_GATED || mode_q == MODE_CELL) begin
          state_d = ST_SIG;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_SIG:  state_d = ST_GATE;
      ST_GATE: state_d = ST_MULA;
      ST_MULA: state_d = (mode_q == MODE_CELL) ? ST_DVST : ST_MULB;
      ST_DVST: state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_MULB;
      ST_MULB: state_d = ST_MULC;
      ST_MULC: state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      mode_q   <= mode_i;
      sa_q     <= sum_a_i;
      sb_q     <= sum_b_i;
      bias_a_q <= bias_a_i;
      bias_b_q <= bias_b_i;
      decay_q  <= decay_i;
      prev_q   <= prev_i;
    end
    if (state_q == ST_PREP) begin
      xs_q <= xs_d;
      xt_q <= xt_d;
    end
    if (state_q == ST_SIG) begin
      sig_prod_q <= sig_prod_d;
      x2_q       <= x2_d;
    end
    if (state_q == ST_GATE) begin
      g_q    <= g_d;
      tsum_q <= tsum_d;
      den_q  <= den_d;
    end
    if (state_q == ST_MULA) begin
      gprod_q <= gprod_d;
      mag_q   <= mag_d;
      keep1_q <= keep1_d;
    end
    if (state_q == ST_MULB) begin
      silu_c_q <= silu_c_d;
      sumb_c_q <= sumb_c_d;
      c_q      <= c_d;
    end
    if (state_q == ST_MULC) begin
      p_q    <= p_d;
      keep_q <= keep_d;
      mix_q  <= mix_d;
    end
    if (state_q == ST_OUT) begin
      result_q <= result_d;
      sat_q    <= sat_d;
    end
  end

  assign stat_o.busy  = (state_q != ST_IDLE);
  assign stat_o.done  = (state_q == ST_OUT);
  assign result_o     = result_q;
  assign saturated_o  = sat_q;

endmodule

`default_nettype wire

[sv/ternary_row_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ternary_row_engine_assert.svh"
// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   weight_a_i, weight_b_i, act0_i..act3_i, row_end_i,
//                                     bias_a_i, bias_b_i, decay_factor_i, prev_state_i
// output    out_valid_o / out_stall_i result_o, saturated_o
// config    psel/penable/pwrite       paddr, pwdata, prdata (mode at byte address 0)
//
// A transfer without row end is taken every cycle, lanes and merge work in that cycle.
// A row-end transfer starts the finishing sequencer: plain mode goes straight to output,
// gated mode adds sigmoid and product states, recurrent mode the 14-step tanh divider too.
// Items of the next row keep flowing while the sequencer runs; a row-end transfer
// waits while the sequencer is busy or the output register still holds a result.
// Reset clears the accumulators, the mode register, the sequencer and output valid.

module ternary_row_engine #(
  parameter int ACT_WIDTH = tre_pkg::ACT_WIDTH_DEF,
  parameter int ACC_WIDTH = tre_pkg::ACC_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tre_pkg::WEIGHT_W-1:0]      weight_a_i,
  input  logic [tre_pkg::WEIGHT_W-1:0]      weight_b_i,
  input  logic signed [ACT_WIDTH-1:0]       act0_i,
  input  logic signed [ACT_WIDTH-1:0]       act1_i,
  input  logic signed [ACT_WIDTH-1:0]       act2_i,
  input  logic signed [ACT_WIDTH-1:0]       act3_i,
  input  logic                              row_end_i,
  input  logic signed [tre_pkg::BIAS_W-1:0] bias_a_i,
  input  logic signed [tre_pkg::BIAS_W-1:0] bias_b_i,
  input  logic [tre_pkg::DECAY_W-1:0]       decay_factor_i,
  input  logic signed [tre_pkg::PREV_W-1:0] prev_state_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tre_pkg::OUT_W-1:0]  result_o,
  output logic                              saturated_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tre_pkg::PADDR_W-1:0]       paddr,
  input  logic [tre_pkg::PDATA_W-1:0]       pwdata,
  output logic [tre_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import tre_pkg::*;

  logic signed [ACT_WIDTH-1:0] acts [LANES];
  logic signed [ACC_WIDTH-1:0] sum_a, sum_b;
  logic [MODE_W-1:0]           mode_q;
  logic                        out_valid_q;
  logic                        in_xfer, out_xfer, cfg_wr;
  fin_stat_t                   fin_stat;

  assign acts[0] = act0_i;
  assign acts[1] = act1_i;
  assign acts[2] = act2_i;
  assign acts[3] = act3_i;

  // Hold a row-end transfer until the sequencer and output register are free.
  assign in_stall_o = row_end_i & (fin_stat.busy | out_valid_q);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_xfer   = out_valid_q & ~out_stall_i;

  // Configuration: mode is the only register, other word addresses drop writes.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_MODE_IDX);
  assign prdata = (paddr[2] == REG_MODE_IDX) ? {{(PDATA_W-MODE_W){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
    end else if (cfg_wr) begin
      mode_q <= pwdata[MODE_W-1:0];
    end
  end

  tre_accum #(
    .ACT_WIDTH (ACT_WIDTH),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_xfer),
    .row_end_i  (row_end_i),
    .weight_a_i (weight_a_i),
    .weight_b_i (weight_b_i),
    .act_i      (acts),
    .sum_a_o    (sum_a),
    .sum_b_o    (sum_b)
  );

  tre_finish #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer & row_end_i),
    .mode_i      (mode_q),
    .sum_a_i     (sum_a),
    .sum_b_i     (sum_b),
    .bias_a_i    (bias_a_i),
    .bias_b_i    (bias_b_i),
    .decay_i     (decay_factor_i),
    .prev_i      (prev_state_i),
    .stat_o      (fin_stat),
    .result_o    (result_o),
    .saturated_o (saturated_o)
  );

  // Advance output valid on sequencer completion, drop it on the output transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_stat.done) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `TRE_ASSERT(a_done_slot_free, clk_i, rst_ni, fin_stat.done |-> !out_valid_q, "result finished while output register full")
  `TRE_ASSERT(a_row_end_starts, clk_i, rst_ni, (in_xfer && row_end_i) |=> fin_stat.busy, "row end did not start the sequencer")
  `TRE_ASSERT_NEVER(a_busy_with_result, clk_i, rst_ni, out_valid_q && fin_stat.busy, "sequencer busy while a result waits")

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import tre_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX = 10;
  localparam logic [PADDR_W-1:0] ADDR_MODE = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [WEIGHT_W-1:0] wa;
    logic [WEIGHT_W-1:0] wb;
    logic [3:0][15:0] act;
    logic row_end;
    logic [BIAS_W-1:0] ba;
    logic [BIAS_W-1:0] bb;
    logic [DECAY_W-1:0] decay;
    logic [PREV_W-1:0] prev;
  } row_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic clipped;
  } neuron_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [WEIGHT_W-1:0] weight_a_i = '0, weight_b_i = '0;
  logic signed [15:0] act0_i = '0, act1_i = '0, act2_i = '0, act3_i = '0;
  logic row_end_i = 1'b0;
  logic signed [BIAS_W-1:0] bias_a_i = '0, bias_b_i = '0;
  logic [DECAY_W-1:0] decay_factor_i = '0;
  logic signed [PREV_W-1:0] prev_state_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] result_o;
  logic saturated_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  ternary_row_engine dut (.*);

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: mirrors the block's mode register and accumulators.
  logic [1:0] mode_shadow = MODE_PLAIN;
  longint acc_a = 0, acc_b = 0;
  neuron_out_t pending_outs[$];

  int mismatches = 0;
  int items_sent = 0;
  int rows_done = 0;
  int burst_left = 0;
  int hold_cycles = 0;
  int stall_pct = 0;
  longint cycles = 0;

  function automatic longint sat_range(longint v, int w, output bit hit);
    longint lim;
    lim = longint'(1) <<< (w - 1);
    hit = 1'b0;
    if (v > lim - 1) begin
      hit = 1'b1;
      return lim - 1;
    end
    if (v < -lim) begin
      hit = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  // Round to nearest, halves toward plus infinity.
  function automatic longint round_down_by(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_mag(longint v, longint c);
    if (v > c) return c;
    if (v < -c) return -c;
    return v;
  endfunction

  function automatic longint sigmoid_fix(longint x);
    longint ax, inner;
    if (x < -4 * ONE_Q) return 0;
    if (x > 4 * ONE_Q) return ONE_Q;
    ax = (x < 0) ? -x : x;
    inner = (longint'(1) <<< 22) - 128 * ax;
    return HALF_Q + round_down_by(x * inner, 24);
  endfunction

  function automatic longint tanh_fix(longint x);
    longint x2, num, den, mag, q;
    if (x < -3 * ONE_Q) return -ONE_Q;
    if (x > 3 * ONE_Q) return ONE_Q;
    x2 = x * x;
    num = x * (27 * (longint'(1) <<< 24) + x2);
    den = 27 * (longint'(1) <<< 24) + 9 * x2;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Accumulate one transfer; at row end queue the neuron output.
  function automatic void predict_neuron(row_item_t it);
    longint da, db, a, r, silu, g, c;
    logic [1:0] ta, tb;
    bit hit;
    neuron_out_t o;
    da = 0;
    db = 0;
    for (int k = 0; k < LANES; k++) begin
      a = longint'($signed(it.act[k]));
      ta = it.wa[2*k +: 2];
      tb = it.wb[2*k +: 2];
      if (ta == TRIT_POS) da += a;
      else if (ta == TRIT_NEG) da -= a;
      if (tb == TRIT_POS) db += a;
      else if (tb == TRIT_NEG) db -= a;
    end
    acc_a = sat_range(acc_a + da, ACC_WIDTH_DEF, hit);
    acc_b = sat_range(acc_b + db, ACC_WIDTH_DEF, hit);
    if (!it.row_end) return;
    if (mode_shadow == MODE_GATED) begin
      silu = round_down_by(acc_a * sigmoid_fix(acc_a), FRAC);
      r = round_down_by(clamp_mag(silu, GATE_CLAMP) * clamp_mag(acc_b, GATE_CLAMP), FRAC);
    end else if (mode_shadow == MODE_CELL) begin
      g = sigmoid_fix(acc_a + longint'($signed(it.ba)));
      c = tanh_fix(acc_b + longint'($signed(it.bb)));
      r = round_down_by((ONE_Q - g) * longint'($signed(it.prev)) * longint'(it.decay)
                        + g * c * ONE_Q, 24);
    end else begin
      r = acc_a;
    end
    r = sat_range(r, OUT_W, hit);
    o.value = r[OUT_W-1:0];
    o.clipped = hit;
    pending_outs.push_back(o);
    acc_a = 0;
    acc_b = 0;
  endfunction

  // Send one item; the sender works in bursts with random gaps between them.
  task automatic send_item(row_item_t it);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    weight_a_i <= it.wa;
    weight_b_i <= it.wb;
    act0_i <= it.act[0];
    act1_i <= it.act[1];
    act2_i <= it.act[2];
    act3_i <= it.act[3];
    row_end_i <= it.row_end;
    bias_a_i <= it.ba;
    bias_b_i <= it.bb;
    decay_factor_i <= it.decay;
    prev_state_i <= it.prev;
    do @(posedge clk_i); while (in_stall_o);
    predict_neuron(it);
    items_sent++;
    if (it.row_end) rows_done++;
    burst_left--;
  endtask

  // Drop valid and wait until every expected output has arrived.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_outs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write the given address, mirror a mode write, then read the mode register back.
  task automatic set_mode(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    wait_idle();
    apb_write(addr, data);
    if (addr == ADDR_MODE) mode_shadow = data[1:0];
    @(posedge clk_i);
    psel <= 1'b1;
    paddr <= ADDR_MODE;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[1:0] !== mode_shadow) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mode readback: expected %0d got %0d", mode_shadow, prdata[1:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_act(int mag);
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 2 * mag)) - mag);
    endcase
  endfunction

  function automatic row_item_t make_item(bit last, int mag);
    row_item_t it;
    it.wa = 8'($urandom);
    it.wb = 8'($urandom);
    for (int k = 0; k < LANES; k++) it.act[k] = pick_act(mag);
    it.row_end = last;
    it.ba = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 40000)) - 20000);
    it.bb = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 30000)) - 15000);
    it.decay = ($urandom_range(0, 4) == 0) ? 13'($urandom) : 13'($urandom_range(0, ONE_Q));
    it.prev = 16'($urandom);
    return it;
  endfunction

  task automatic send_row(int len, int mag);
    for (int i = 0; i < len; i++) send_item(make_item(i == len - 1, mag));
  endtask

  // One single-item row with the same activation on all lanes.
  task automatic send_flat(logic [7:0] wa, logic [7:0] wb, logic [15:0] a,
                           logic [15:0] ba, logic [15:0] bb, logic [12:0] dec,
                           logic [15:0] prev);
    row_item_t it;
    it.wa = wa;
    it.wb = wb;
    it.act = {a, a, a, a};
    it.row_end = 1'b1;
    it.ba = ba;
    it.bb = bb;
    it.decay = dec;
    it.prev = prev;
    send_item(it);
  endtask

  // Plain dot: trit codes, zero and code 3, saturation both ways, non-final items.
  task automatic test_plain_dot();
    set_mode(ADDR_MODE, MODE_PLAIN);
    send_flat(8'h55, 8'h00, 16'h7fff, 0, 0, 0, 0);
    send_flat(8'hAA, 8'hFF, 16'h7fff, 0, 0, 0, 0);
    send_flat(8'hAA, 8'h55, 16'h8000, 0, 0, 0, 0);
    send_flat(8'hFF, 8'hAA, 16'h8000, 0, 0, 0, 0);
    send_flat(8'h01, 8'h02, 16'h1234, 0, 0, 0, 0);
    send_flat(8'h00, 8'hFF, 16'h7fff, 0, 0, 0, 0);
    send_row(5, 3000);
  endtask

  // Gated: sigmoid edges at +-4 and beyond, large operands saturating the output.
  task automatic test_gated();
    set_mode(ADDR_MODE, MODE_GATED);
    send_flat(8'h01, 8'h01, 16'd16384, 0, 0, 0, 0);
    send_flat(8'h01, 8'h01, -16'sd16384, 0, 0, 0, 0);
    send_flat(8'h01, 8'h01, 16'd16385, 0, 0, 0, 0);
    send_flat(8'h01, 8'h02, -16'sd4097, 0, 0, 0, 0);
    send_flat(8'h55, 8'h55, 16'h7fff, 0, 0, 0, 0);
    send_flat(8'h55, 8'hAA, 16'h8000, 0, 0, 0, 0);
    send_row(3, 2000);
  endtask

  // Recurrent: decay extremes, tanh edges at +-3, bias and state extremes.
  task automatic test_cell_update();
    set_mode(ADDR_MODE, MODE_CELL);
    send_flat(8'h00, 8'h00, 0, 16'h8000, 16'd12288, 13'd0, 16'h7fff);
    send_flat(8'h00, 8'h00, 0, 16'h7fff, -16'sd12288, 13'd4096, 16'h8000);
    send_flat(8'h00, 8'h00, 0, 16'h8000, 16'd12289, 13'h1fff, 16'h7fff);
    send_flat(8'h00, 8'h00, 0, 16'h0000, -16'sd12289, 13'h1fff, 16'h8000);
    send_flat(8'h01, 8'h02, 16'd3000, 16'd100, 16'd50, 13'd3000, 16'd5000);
    send_row(4, 3000);
  endtask

  // Spare mode code acts as plain dot; writes outside the mode register are dropped.
  task automatic test_spare_codes();
    set_mode(ADDR_MODE, 32'hFFFF_FFF0 | MODE_SPARE);
    send_flat(8'h55, 8'h00, 16'h7fff, 0, 0, 0, 0);
    send_row(3, 4000);
    set_mode(ADDR_UNMAPPED, MODE_GATED);
    send_row(2, 4000);
  endtask

  task automatic test_random_rows();
    logic [1:0] modes[4] = '{MODE_PLAIN, MODE_GATED, MODE_CELL, MODE_SPARE};
    for (int phase = 0; phase < 8; phase++) begin
      set_mode(ADDR_MODE, modes[phase % 4]);
      for (int n = 0; n < 120; ) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 5);
        send_row(len, (phase < 4) ? 6000 : 1500);
        n += len;
      end
    end
  endtask

  // Hold the output off while rows keep coming, so the block backs up.
  task automatic test_backpressure();
    set_mode(ADDR_MODE, MODE_CELL);
    hold_cycles = 400;
    burst_left = 1000;
    for (int i = 0; i < 30; i++) send_row($urandom_range(1, 3), 4000);
  endtask

  // Own hold-off counter, separate from the receiver's stall pattern.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // Receiver: switch between random stall densities, and stall while the hold-off counter runs.
  always @(posedge clk_i) begin
    if (cycles % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    out_stall_i <= (hold_cycles > 1) || ($urandom_range(0, 99) < stall_pct);
  end

  // Compare every output transfer with the oldest pending expectation.
  always @(posedge clk_i) begin
    neuron_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected output: result %0d sat %0b", result_o, saturated_o);
      end else begin
        want = pending_outs.pop_front();
        if (result_o !== want.value || saturated_o !== want.clipped) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("output mismatch: expected %0d/%0b got %0d/%0b",
                     $signed(want.value), want.clipped, result_o, saturated_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** ternary_row_engine: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_dot();
    test_gated();
    test_cell_update();
    test_spare_codes();
    test_random_rows();
    test_backpressure();
    wait_idle();
    if (pending_outs.size() != 0) mismatches++;
    $display("covered %0d items in %0d rows over all modes, with stalls and a long hold-off",
             items_sent, rows_done);
    if (mismatches == 0) begin
      $display("** ternary_row_engine: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** ternary_row_engine: FAILED **");
    end
    $finish;
  end

endmodule
